[sv/ppr_pkg.sv]
`timescale 1ns / 1ps

package ppr_pkg;

   localparam int CAM_W = 52;
   localparam int MAG_W = 51;
   localparam int INT_BITS = 7;
   localparam int REM_W = MAG_W + INT_BITS;
   localparam int QUO_W = 31;

   localparam logic [2:0] CSR_ROT_ROW0 = 3'd0;
   localparam logic [2:0] CSR_ROT_ROW1 = 3'd1;
   localparam logic [2:0] CSR_ROT_ROW2 = 3'd2;
   localparam logic [2:0] CSR_TRANS    = 3'd3;
   localparam logic [2:0] CSR_DIST     = 3'd4;
   localparam logic [2:0] CSR_WIDTH    = 3'd5;
   localparam logic [2:0] CSR_HEIGHT   = 3'd6;

   localparam logic [53:0] ROT_ROW0_RST = 54'd65536;
   localparam logic [53:0] ROT_ROW1_RST = 54'd65536 << 18;
   localparam logic [53:0] ROT_ROW2_RST = 54'd65536 << 36;
   localparam logic [15:0] WIDTH_RST    = 16'd640;
   localparam logic [15:0] HEIGHT_RST   = 16'd480;

   localparam logic [31:0] S32_MAX_BITS = 32'h7fff_ffff;
   localparam logic [31:0] S32_MIN_BITS = 32'h8000_0000;

   typedef struct packed {
      logic             zpos;
      logic             neg_x;
      logic             neg_y;
      logic             ovf_x;
      logic             ovf_y;
      logic [REM_W-1:0] den;
      logic [REM_W-1:0] rem_x;
      logic [REM_W-1:0] rem_y;
      logic [QUO_W-1:0] quo_x;
      logic [QUO_W-1:0] quo_y;
   } div_stage_type;

   // one restoring step for each of the two quotients
   function automatic div_stage_type div_step(input div_stage_type s);
      div_stage_type r;
      logic [REM_W-1:0] tx;
      logic [REM_W-1:0] ty;
      r = s;
      tx = {s.rem_x[REM_W-2:0], 1'b0};
      ty = {s.rem_y[REM_W-2:0], 1'b0};
      if (tx >= s.den) begin
         r.rem_x = tx - s.den;
         r.quo_x = {s.quo_x[QUO_W-2:0], 1'b1};
      end else begin
         r.rem_x = tx;
         r.quo_x = {s.quo_x[QUO_W-2:0], 1'b0};
      end
      if (ty >= s.den) begin
         r.rem_y = ty - s.den;
         r.quo_y = {s.quo_y[QUO_W-2:0], 1'b1};
      end else begin
         r.rem_y = ty;
         r.quo_y = {s.quo_y[QUO_W-2:0], 1'b0};
      end
      return r;
   endfunction

   // saturation flag above the clamped value
   function automatic logic [32:0] sat32(input logic signed [63:0] x);
      logic [32:0] r;
      priority if (x > 64'sd2147483647) begin
         r = {1'b1, S32_MAX_BITS};
      end else if (x < -64'sd2147483648) begin
         r = {1'b1, S32_MIN_BITS};
      end else begin
         r = {1'b0, x[31:0]};
      end
      return r;
   endfunction

endpackage

[sv/point_projection_radial_distortion.sv]
`timescale 1ns / 1ps

// Projects one world point (Q16.16) per beat through the configured pose, a perspective
// divide, the k1/k2 radial distortion and the image scale and offset, giving pixel
// coordinates in Q24.8 with an invalid flag for non-positive depth or saturation. One point
// is taken every cycle; most of the pipeline is made up of the two 31-stage restoring
// dividers that run side by side, one quotient bit per stage. The whole pipeline holds
// while a finished result is not taken. Configuration is read live, so write it only
// while no point is in flight.
module point_projection_radial_distortion (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [95:0] req_tdata,   // point_x, point_y, point_z
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,   // pixel_x, pixel_y
   output logic [0:0]  rsp_tuser,   // invalid
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [63:0] csr_wdata
);

   localparam int CAM_W = ppr_pkg::CAM_W;
   localparam int MAG_W = ppr_pkg::MAG_W;
   localparam int QUO_W = ppr_pkg::QUO_W;

   logic [53:0] rot_ff [3];
   logic [62:0] trans_ff;
   logic [63:0] dist_cfg_ff;
   logic [15:0] width_ff;
   logic [15:0] height_ff;

   logic ce;
   logic v1_ff, v2_ff;
   logic [QUO_W:0] dv_ff;
   logic v4_ff, v5_ff, v6_ff, v7_ff, v8_ff, v9_ff, v10_ff, v11_ff, v12_ff, v13_ff;

   logic signed [49:0]      prod_ff [3][3];
   logic signed [44:0]      tterm_ff [3];
   logic signed [CAM_W-1:0] cam_ff [3];
   ppr_pkg::div_stage_type  div_ff [QUO_W+1];
   ppr_pkg::div_stage_type  div_in;

   logic signed [31:0] s4_u_ff, s4_v_ff;
   logic               s4_sat_ff, s4_zpos_ff;
   logic signed [63:0] s5_uu_ff, s5_vv_ff;
   logic signed [31:0] s5_u_ff, s5_v_ff;
   logic               s5_sat_ff, s5_zpos_ff;
   logic [39:0]        s6_r2_ff;
   logic signed [31:0] s6_u_ff, s6_v_ff;
   logic               s6_sat_ff, s6_zpos_ff;
   logic [55:0]        s7_r2hi_ff;
   logic [63:0]        s7_r2lo_ff;
   logic signed [48:0] s7_k1hi_ff;
   logic signed [56:0] s7_k1lo_ff;
   logic signed [31:0] s7_u_ff, s7_v_ff;
   logic               s7_sat_ff, s7_zpos_ff;
   logic [54:0]        s8_r4_ff;
   logic signed [48:0] s8_ka_ff;
   logic signed [31:0] s8_u_ff, s8_v_ff;
   logic               s8_sat_ff, s8_zpos_ff;
   logic signed [63:0] s9_k2hi_ff;
   logic signed [56:0] s9_k2lo_ff;
   logic signed [48:0] s9_ka_ff;
   logic signed [31:0] s9_u_ff, s9_v_ff;
   logic               s9_sat_ff, s9_zpos_ff;
   logic signed [31:0] s10_dist_ff;
   logic signed [31:0] s10_u_ff, s10_v_ff;
   logic               s10_sat_ff, s10_zpos_ff;
   logic signed [63:0] s11_ud_ff, s11_vd_ff;
   logic               s11_sat_ff, s11_zpos_ff;
   logic signed [56:0] s12_px_ff, s12_py_ff;
   logic               s12_sat_ff, s12_zpos_ff;
   logic [31:0]        s13_px_ff, s13_py_ff;
   logic               s13_inv_ff;

   logic signed [63:0] dist_sum_in;
   logic [32:0]        dist_sat_in;
   logic [16:0]        size_sum;
   logic [15:0]        scale;
   logic signed [63:0] pix_x_in, pix_y_in;
   logic [32:0]        pix_x_sat, pix_y_sat;
   logic signed [CAM_W-1:0] abs_x, abs_y;

   assign ce         = !rsp_tvalid || rsp_tready;
   assign req_tready = ce;
   assign rsp_tvalid = v13_ff;
   assign rsp_tdata  = {s13_py_ff, s13_px_ff};
   assign rsp_tuser  = s13_inv_ff;

   // configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         rot_ff[0]   <= ppr_pkg::ROT_ROW0_RST;
         rot_ff[1]   <= ppr_pkg::ROT_ROW1_RST;
         rot_ff[2]   <= ppr_pkg::ROT_ROW2_RST;
         trans_ff    <= '0;
         dist_cfg_ff <= '0;
         width_ff    <= ppr_pkg::WIDTH_RST;
         height_ff   <= ppr_pkg::HEIGHT_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            ppr_pkg::CSR_ROT_ROW0: rot_ff[0]   <= csr_wdata[53:0];
            ppr_pkg::CSR_ROT_ROW1: rot_ff[1]   <= csr_wdata[53:0];
            ppr_pkg::CSR_ROT_ROW2: rot_ff[2]   <= csr_wdata[53:0];
            ppr_pkg::CSR_TRANS:    trans_ff    <= csr_wdata[62:0];
            ppr_pkg::CSR_DIST:     dist_cfg_ff <= csr_wdata;
            ppr_pkg::CSR_WIDTH:    width_ff    <= csr_wdata[15:0];
            ppr_pkg::CSR_HEIGHT:   height_ff   <= csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff  <= 1'b0;
         v2_ff  <= 1'b0;
         dv_ff  <= '0;
         v4_ff  <= 1'b0;
         v5_ff  <= 1'b0;
         v6_ff  <= 1'b0;
         v7_ff  <= 1'b0;
         v8_ff  <= 1'b0;
         v9_ff  <= 1'b0;
         v10_ff <= 1'b0;
         v11_ff <= 1'b0;
         v12_ff <= 1'b0;
         v13_ff <= 1'b0;
      end else if (ce) begin
         v1_ff  <= req_tvalid;
         v2_ff  <= v1_ff;
         dv_ff  <= {dv_ff[QUO_W-1:0], v2_ff};
         v4_ff  <= dv_ff[QUO_W];
         v5_ff  <= v4_ff;
         v6_ff  <= v5_ff;
         v7_ff  <= v6_ff;
         v8_ff  <= v7_ff;
         v9_ff  <= v8_ff;
         v10_ff <= v9_ff;
         v11_ff <= v10_ff;
         v12_ff <= v11_ff;
         v13_ff <= v12_ff;
      end
   end

   // divider set-up
   always_comb begin
      abs_x = cam_ff[0][CAM_W-1] ? -cam_ff[0] : cam_ff[0];
      abs_y = cam_ff[1][CAM_W-1] ? -cam_ff[1] : cam_ff[1];
      div_in.zpos  = !cam_ff[2][CAM_W-1] && (cam_ff[2] != '0);
      div_in.neg_x = cam_ff[0][CAM_W-1];
      div_in.neg_y = cam_ff[1][CAM_W-1];
      div_in.den   = {cam_ff[2][MAG_W-1:0], {ppr_pkg::INT_BITS{1'b0}}};
      div_in.rem_x = {{ppr_pkg::INT_BITS{1'b0}}, abs_x[MAG_W-1:0]};
      div_in.rem_y = {{ppr_pkg::INT_BITS{1'b0}}, abs_y[MAG_W-1:0]};
      div_in.ovf_x = div_in.rem_x >= div_in.den;
      div_in.ovf_y = div_in.rem_y >= div_in.den;
      div_in.quo_x = '0;
      div_in.quo_y = '0;
   end

   always_comb begin
      size_sum    = {1'b0, width_ff} + {1'b0, height_ff};
      scale       = size_sum[16:1];
      dist_sum_in = 64'sd16777216 + 64'(s9_ka_ff) + s9_k2hi_ff + 64'(s9_k2lo_ff >>> 24);
      dist_sat_in = ppr_pkg::sat32(dist_sum_in);
      pix_x_in    = 64'(s12_px_ff >>> 16) + $signed(64'({width_ff[15:1], 8'b0}));
      pix_y_in    = 64'(s12_py_ff >>> 16) + $signed(64'({height_ff[15:1], 8'b0}));
      pix_x_sat   = ppr_pkg::sat32(pix_x_in);
      pix_y_sat   = ppr_pkg::sat32(pix_y_in);
   end

   // datapath
   always_ff @(posedge clock) begin
      if (ce) begin
         for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
               prod_ff[i][j] <= $signed(rot_ff[i][18*j +: 18]) * $signed(req_tdata[32*j +: 32]);
            end
            tterm_ff[i] <= $signed({trans_ff[21*i +: 21], 24'b0});
            cam_ff[i]   <= CAM_W'(prod_ff[i][0]) + CAM_W'(prod_ff[i][1])
                         + CAM_W'(prod_ff[i][2]) + CAM_W'(tterm_ff[i]);
         end

         div_ff[0] <= div_in;
         for (int k = 0; k < QUO_W; k++) begin
            div_ff[k+1] <= ppr_pkg::div_step(div_ff[k]);
         end

         // normalised coordinates
         priority if (div_ff[QUO_W].ovf_x) begin
            s4_u_ff <= div_ff[QUO_W].neg_x ? ppr_pkg::S32_MIN_BITS : ppr_pkg::S32_MAX_BITS;
         end else begin
            s4_u_ff <= div_ff[QUO_W].neg_x ? -$signed({1'b0, div_ff[QUO_W].quo_x})
                                           : $signed({1'b0, div_ff[QUO_W].quo_x});
         end
         priority if (div_ff[QUO_W].ovf_y) begin
            s4_v_ff <= div_ff[QUO_W].neg_y ? ppr_pkg::S32_MIN_BITS : ppr_pkg::S32_MAX_BITS;
         end else begin
            s4_v_ff <= div_ff[QUO_W].neg_y ? -$signed({1'b0, div_ff[QUO_W].quo_y})
                                           : $signed({1'b0, div_ff[QUO_W].quo_y});
         end
         s4_sat_ff  <= div_ff[QUO_W].ovf_x || div_ff[QUO_W].ovf_y;
         s4_zpos_ff <= div_ff[QUO_W].zpos;

         s5_uu_ff   <= s4_u_ff * s4_u_ff;
         s5_vv_ff   <= s4_v_ff * s4_v_ff;
         s5_u_ff    <= s4_u_ff;
         s5_v_ff    <= s4_v_ff;
         s5_sat_ff  <= s4_sat_ff;
         s5_zpos_ff <= s4_zpos_ff;

         s6_r2_ff   <= 40'(($unsigned(s5_uu_ff) + $unsigned(s5_vv_ff)) >> 24);
         s6_u_ff    <= s5_u_ff;
         s6_v_ff    <= s5_v_ff;
         s6_sat_ff  <= s5_sat_ff;
         s6_zpos_ff <= s5_zpos_ff;

         s7_r2hi_ff <= s6_r2_ff * s6_r2_ff[39:24];
         s7_r2lo_ff <= s6_r2_ff * s6_r2_ff[23:0];
         s7_k1hi_ff <= $signed(dist_cfg_ff[31:0]) * $signed({1'b0, s6_r2_ff[39:24]});
         s7_k1lo_ff <= $signed(dist_cfg_ff[31:0]) * $signed({1'b0, s6_r2_ff[23:0]});
         s7_u_ff    <= s6_u_ff;
         s7_v_ff    <= s6_v_ff;
         s7_sat_ff  <= s6_sat_ff;
         s7_zpos_ff <= s6_zpos_ff;

         s8_r4_ff   <= 55'(64'(s7_r2hi_ff) + {24'b0, s7_r2lo_ff[63:24]});
         s8_ka_ff   <= s7_k1hi_ff + 49'(s7_k1lo_ff >>> 24);
         s8_u_ff    <= s7_u_ff;
         s8_v_ff    <= s7_v_ff;
         s8_sat_ff  <= s7_sat_ff;
         s8_zpos_ff <= s7_zpos_ff;

         s9_k2hi_ff <= $signed(dist_cfg_ff[63:32]) * $signed({1'b0, s8_r4_ff[54:24]});
         s9_k2lo_ff <= $signed(dist_cfg_ff[63:32]) * $signed({1'b0, s8_r4_ff[23:0]});
         s9_ka_ff   <= s8_ka_ff;
         s9_u_ff    <= s8_u_ff;
         s9_v_ff    <= s8_v_ff;
         s9_sat_ff  <= s8_sat_ff;
         s9_zpos_ff <= s8_zpos_ff;

         s10_dist_ff <= $signed(dist_sat_in[31:0]);
         s10_u_ff    <= s9_u_ff;
         s10_v_ff    <= s9_v_ff;
         s10_sat_ff  <= s9_sat_ff || dist_sat_in[32];
         s10_zpos_ff <= s9_zpos_ff;

         s11_ud_ff   <= s10_u_ff * s10_dist_ff;
         s11_vd_ff   <= s10_v_ff * s10_dist_ff;
         s11_sat_ff  <= s10_sat_ff;
         s11_zpos_ff <= s10_zpos_ff;

         s12_px_ff   <= $signed(40'(s11_ud_ff >>> 24)) * $signed({1'b0, scale});
         s12_py_ff   <= $signed(40'(s11_vd_ff >>> 24)) * $signed({1'b0, scale});
         s12_sat_ff  <= s11_sat_ff;
         s12_zpos_ff <= s11_zpos_ff;

         s13_px_ff  <= s12_zpos_ff ? pix_x_sat[31:0] : ppr_pkg::S32_MAX_BITS;
         s13_py_ff  <= s12_zpos_ff ? pix_y_sat[31:0] : ppr_pkg::S32_MAX_BITS;
         s13_inv_ff <= !s12_zpos_ff || s12_sat_ff || pix_x_sat[32] || pix_y_sat[32];
      end
   end

`ifndef ASSERT_OFF
   // behind-the-camera points leave flagged and pinned to the positive limit
   assert property (@(posedge clock) disable iff (reset)
      ce && v12_ff && !s12_zpos_ff |=>
         rsp_tuser[0] && rsp_tdata[31:0] == ppr_pkg::S32_MAX_BITS
         && rsp_tdata[63:32] == ppr_pkg::S32_MAX_BITS)
      else $error("non-positive depth not flagged");

   // a clamped quotient carries its saturation forward
   assert property (@(posedge clock) disable iff (reset)
      ce && dv_ff[QUO_W] && (div_ff[QUO_W].ovf_x || div_ff[QUO_W].ovf_y) |=> s4_sat_ff)
      else $error("divider overflow lost");

   // restoring remainder stays below the shifted divisor
   assert property (@(posedge clock) disable iff (reset)
      dv_ff[QUO_W] && div_ff[QUO_W].zpos && !div_ff[QUO_W].ovf_x |->
         div_ff[QUO_W].rem_x < div_ff[QUO_W].den)
      else $error("divider remainder out of range");
`endif

endmodule
